FILE: hw/rtl/bvp_pkg.sv
`timescale 1ns / 1ps

package bvp_pkg;

  // Curve size and field widths
  localparam int CURVE_POINTS = 11;
  localparam int SEGMENTS     = CURVE_POINTS - 1;
  localparam int ADC_W        = 12;
  localparam int RATIO_W      = 3;
  localparam int WIN_W        = 14;
  localparam int MV_W         = ADC_W + RATIO_W;
  localparam int PCT_W        = 7;
  localparam int REG_IDX_W    = 2;

  // Reciprocal scaling for the per-segment divide: q = (diff * K) >> RECIP_SHIFT
  localparam int RECIP_SHIFT  = 20;
  localparam int K_W          = 28;

  // LiPo discharge curve, highest voltage first
  localparam logic [MV_W-1:0] CURVE_MV [CURVE_POINTS] = '{
    15'd4200, 15'd4060, 15'd3980, 15'd3900, 15'd3830, 15'd3750,
    15'd3680, 15'd3600, 15'd3500, 15'd3350, 15'd3000
  };
  localparam logic [PCT_W-1:0] CURVE_PCT [CURVE_POINTS] = '{
    7'd100, 7'd90, 7'd80, 7'd70, 7'd60, 7'd50,
    7'd40, 7'd30, 7'd20, 7'd10, 7'd0
  };

  localparam logic [PCT_W-1:0] FULL_PCT = 7'd100;

  // Register reset values
  localparam logic [WIN_W-1:0]   VALID_MIN_RST = 14'd2700;
  localparam logic [WIN_W-1:0]   VALID_MAX_RST = 14'd4350;
  localparam logic [RATIO_W-1:0] RATIO_RST     = 3'd2;

  // Register indexes
  localparam logic [REG_IDX_W-1:0] REG_VALID_MIN = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_VALID_MAX = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_RATIO     = 2'd2;

  // Sample travelling down the cell chain
  typedef struct packed {
    logic             valid;
    logic             done;
    logic [MV_W-1:0]  mv;
    logic [PCT_W-1:0] level;
    logic             ext;
  } item_t;

  // Fixed constants of one curve segment
  typedef struct packed {
    logic [MV_W-1:0]  vlo;
    logic [PCT_W-1:0] plo;
    logic [K_W-1:0]   k;
  } seg_t;

endpackage

FILE: hw/rtl/bvp_front.sv
`timescale 1ns / 1ps

module bvp_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          adv,
  input  logic                          in_valid,
  input  logic [bvp_pkg::ADC_W-1:0]     adc_mv,
  input  logic                          read_ok,
  input  logic [bvp_pkg::WIN_W-1:0]     valid_min_mv,
  input  logic [bvp_pkg::WIN_W-1:0]     valid_max_mv,
  input  logic [bvp_pkg::RATIO_W-1:0]   divider_ratio,
  output bvp_pkg::item_t                item
);

  logic [bvp_pkg::MV_W-1:0]  mv;
  logic                      ext;
  logic                      above_top;
  logic                      below_bot;
  logic [bvp_pkg::PCT_W-1:0] level;

  // Scale to battery millivolts and classify against window and curve ends
  always_comb begin
    mv = bvp_pkg::MV_W'(adc_mv) * bvp_pkg::MV_W'(divider_ratio);
    ext = (mv < bvp_pkg::MV_W'(valid_min_mv)) || (mv > bvp_pkg::MV_W'(valid_max_mv));
    above_top = mv >= bvp_pkg::CURVE_MV[0];
    below_bot = mv <= bvp_pkg::CURVE_MV[bvp_pkg::CURVE_POINTS-1];
    if (ext || above_top) begin
      level = ext ? bvp_pkg::FULL_PCT : bvp_pkg::CURVE_PCT[0];
    end else begin
      level = bvp_pkg::CURVE_PCT[bvp_pkg::CURVE_POINTS-1];
    end
  end

  // Failed reads enter the chain as bubbles
  always_ff @(posedge clk) begin
    if (rst) begin
      item.valid <= 1'b0;
    end else if (adv) begin
      item.valid <= in_valid && read_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      item.done  <= ext || above_top || below_bot;
      item.mv    <= mv;
      item.level <= level;
      item.ext   <= ext;
    end
  end

endmodule

FILE: hw/rtl/bvp_cell.sv
`timescale 1ns / 1ps

module bvp_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            adv,
  input  bvp_pkg::seg_t   seg,
  input  bvp_pkg::item_t  in_item,
  output bvp_pkg::item_t  out_item
);

  localparam int PROD_W = bvp_pkg::MV_W + bvp_pkg::K_W;

  logic                      hit;
  logic [bvp_pkg::MV_W-1:0]  diff;
  logic [PROD_W-1:0]         prod;
  logic [bvp_pkg::PCT_W-1:0] quot;
  logic [bvp_pkg::PCT_W-1:0] level_next;

  // Interpolate inside this segment when the sample is not yet resolved
  always_comb begin
    hit  = !in_item.done && (in_item.mv >= seg.vlo);
    diff = in_item.mv - seg.vlo;
    prod = PROD_W'(diff) * PROD_W'(seg.k);
    quot = prod[bvp_pkg::RECIP_SHIFT +: bvp_pkg::PCT_W];
    level_next = hit ? (seg.plo + quot) : in_item.level;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_item.valid <= 1'b0;
    end else if (adv) begin
      out_item.valid <= in_item.valid;
    end
  end

  // Hand the sample to the next cell
  always_ff @(posedge clk) begin
    if (adv) begin
      out_item.done  <= in_item.done || hit;
      out_item.mv    <= in_item.mv;
      out_item.level <= level_next;
      out_item.ext   <= in_item.ext;
    end
  end

endmodule

FILE: hw/rtl/bvp_out.sv
`timescale 1ns / 1ps

module bvp_out (
  input  logic                      clk,
  input  logic                      rst,
  input  bvp_pkg::item_t            in_item,
  output logic                      adv,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [bvp_pkg::PCT_W-1:0] out_level,
  output logic                      out_ext
);

  logic                      skid_full;
  logic [bvp_pkg::PCT_W-1:0] skid_level;
  logic                      skid_ext;
  logic                      load;

  // Chain moves whenever the skid slot is free
  assign adv  = !skid_full;
  assign load = adv && in_item.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_full <= 1'b0;
    end else if (load) begin
      // Park the new result if the output transaction is stalled
      if (out_valid && !out_ready) begin
        skid_full <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (out_ready) begin
      // Drain the skid slot into the output register
      out_valid <= skid_full;
      skid_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && out_valid && !out_ready) begin
      skid_level <= in_item.level;
      skid_ext   <= in_item.ext;
    end
    if (load && !(out_valid && !out_ready)) begin
      out_level <= in_item.level;
      out_ext   <= in_item.ext;
    end else if (!load && out_ready && skid_full) begin
      out_level <= skid_level;
      out_ext   <= skid_ext;
    end
  end

`ifndef ASSERT_OFF
  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_full |-> out_valid)
    else $error("skid slot holds a result while output register is empty");

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_level <= bvp_pkg::FULL_PCT))
    else $error("battery level above full scale");

  a_ext_full: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ext) |-> (out_level == bvp_pkg::FULL_PCT))
    else $error("external power result not reported as full");

  a_skid_drain: assert property (@(posedge clk) disable iff (rst)
    (skid_full && out_ready) |=> (out_valid && !skid_full))
    else $error("skid slot did not drain on output transaction");
`endif

endmodule

FILE: hw/rtl/battery_voltage_to_percent.sv
`timescale 1ns / 1ps

// Battery voltage to charge percent. Each input transaction carries an ADC
// pin reading in millivolts (tdata) and a read-ok flag (tuser); the reading
// is multiplied by divider_ratio, checked against [valid_min_mv,
// valid_max_mv] (outside: 100 percent with external_power set) and otherwise
// interpolated on a fixed 11-point LiPo curve with truncation. A failed read
// produces no output transaction. The block takes one transaction per cycle
// while the skid slot is free; its stages are one input stage for scaling and
// window check, one cell per curve segment (10), and the output register. A
// two-entry output buffer (register plus skid slot) keeps s_axis_tready free
// of any combinational path from m_axis_tready. Write registers only while idle.
module battery_voltage_to_percent (
  input  logic                            clk,
  input  logic                            rst,
  // Configuration writes
  input  logic                            cfg_we,
  input  logic [bvp_pkg::REG_IDX_W-1:0]   cfg_addr,
  input  logic [bvp_pkg::WIN_W-1:0]       cfg_data,
  // Input stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [15:0]                     s_axis_tdata,   // [11:0] adc_mv, [15:12] zero
  input  logic                            s_axis_tuser,   // [0] read_ok
  // Output stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [7:0]                      m_axis_tdata,   // [6:0] battery_level, [7] zero
  output logic                            m_axis_tuser    // [0] external_power
);

  logic [bvp_pkg::WIN_W-1:0]   valid_min_mv;
  logic [bvp_pkg::WIN_W-1:0]   valid_max_mv;
  logic [bvp_pkg::RATIO_W-1:0] divider_ratio;
  logic                        adv;
  logic [bvp_pkg::PCT_W-1:0]   out_level;
  bvp_pkg::item_t              items [bvp_pkg::SEGMENTS+1];

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_min_mv  <= bvp_pkg::VALID_MIN_RST;
      valid_max_mv  <= bvp_pkg::VALID_MAX_RST;
      divider_ratio <= bvp_pkg::RATIO_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        bvp_pkg::REG_VALID_MIN: valid_min_mv  <= cfg_data;
        bvp_pkg::REG_VALID_MAX: valid_max_mv  <= cfg_data;
        bvp_pkg::REG_RATIO:     divider_ratio <= cfg_data[bvp_pkg::RATIO_W-1:0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = adv;

  bvp_front u_front (
    .clk           (clk),
    .rst           (rst),
    .adv           (adv),
    .in_valid      (s_axis_tvalid),
    .adc_mv        (s_axis_tdata[bvp_pkg::ADC_W-1:0]),
    .read_ok       (s_axis_tuser),
    .valid_min_mv  (valid_min_mv),
    .valid_max_mv  (valid_max_mv),
    .divider_ratio (divider_ratio),
    .item          (items[0])
  );

  // One cell per curve segment, highest segment first
  for (genvar i = 0; i < bvp_pkg::SEGMENTS; i++) begin : g_cell
    localparam int unsigned SPAN =
      32'(bvp_pkg::CURVE_MV[i]) - 32'(bvp_pkg::CURVE_MV[i+1]);
    localparam int unsigned DP   =
      32'(bvp_pkg::CURVE_PCT[i]) - 32'(bvp_pkg::CURVE_PCT[i+1]);
    localparam int unsigned DIV  = (SPAN == 0) ? 1 : SPAN;
    localparam int unsigned K    =
      (SPAN == 0) ? 0 : ((DP << bvp_pkg::RECIP_SHIFT) + DIV - 1) / DIV;

    bvp_pkg::seg_t seg;

    assign seg.vlo = bvp_pkg::CURVE_MV[i+1];
    assign seg.plo = (SPAN == 0) ? bvp_pkg::CURVE_PCT[i] : bvp_pkg::CURVE_PCT[i+1];
    assign seg.k   = bvp_pkg::K_W'(K);

    bvp_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .adv      (adv),
      .seg      (seg),
      .in_item  (items[i]),
      .out_item (items[i+1])
    );
  end

  bvp_out u_out (
    .clk       (clk),
    .rst       (rst),
    .in_item   (items[bvp_pkg::SEGMENTS]),
    .adv       (adv),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_level (out_level),
    .out_ext   (m_axis_tuser)
  );

  assign m_axis_tdata = {1'b0, out_level};

endmodule

FILE: dv/tb_battery_voltage_to_percent.sv
`timescale 1ns / 1ps

module tb_battery_voltage_to_percent;

  // Reading as it should leave the block
  typedef struct {
    logic [bvp_pkg::PCT_W-1:0] level;
    logic                      ext;
  } charge_t;

  // LiPo curve, highest voltage first
  localparam int LIPO_MV [bvp_pkg::CURVE_POINTS] = '{
    4200, 4060, 3980, 3900, 3830, 3750, 3680, 3600, 3500, 3350, 3000
  };
  localparam int LIPO_PCT [bvp_pkg::CURVE_POINTS] = '{
    100, 90, 80, 70, 60, 50, 40, 30, 20, 10, 0
  };
  localparam int DRAIN_CYCLES = 20;

  logic                          clk;
  logic                          rst;
  logic                          cfg_we;
  logic [bvp_pkg::REG_IDX_W-1:0] cfg_addr;
  logic [bvp_pkg::WIN_W-1:0]     cfg_data;
  logic                          s_axis_tvalid;
  logic                          s_axis_tready;
  logic [15:0]                   s_axis_tdata;   // [11:0] adc_mv, [15:12] zero
  logic                          s_axis_tuser;   // [0] read_ok
  logic                          m_axis_tvalid;
  logic                          m_axis_tready;
  logic [7:0]                    m_axis_tdata;   // [6:0] battery_level, [7] zero
  logic                          m_axis_tuser;   // [0] external_power

  // Local copy of the register file
  logic [bvp_pkg::WIN_W-1:0]   window_min_mv;
  logic [bvp_pkg::WIN_W-1:0]   window_max_mv;
  logic [bvp_pkg::RATIO_W-1:0] divider;

  charge_t expected_levels[$];
  int      error_count;
  int      send_idle_pct;
  int      recv_idle_pct;

  battery_voltage_to_percent DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Bound the run
  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  // Interpolate the percent for a battery voltage inside the window
  function automatic int charge_at_mv(int mv);
    int i;
    if (mv >= LIPO_MV[0]) return LIPO_PCT[0];
    if (mv <= LIPO_MV[bvp_pkg::CURVE_POINTS-1]) return LIPO_PCT[bvp_pkg::CURVE_POINTS-1];
    for (i = 0; i < bvp_pkg::CURVE_POINTS - 1; i++) begin
      if (mv >= LIPO_MV[i+1]) begin
        return LIPO_PCT[i+1] + ((LIPO_PCT[i] - LIPO_PCT[i+1]) * (mv - LIPO_MV[i+1]))
               / (LIPO_MV[i] - LIPO_MV[i+1]);
      end
    end
    return 0;
  endfunction

  // Scale, window check, then curve lookup
  function automatic charge_t predict_reading(logic [bvp_pkg::ADC_W-1:0] adc);
    int      mv;
    charge_t r;
    mv = int'(adc) * int'(divider);
    if (mv < int'(window_min_mv) || mv > int'(window_max_mv)) begin
      r.level = bvp_pkg::FULL_PCT;
      r.ext   = 1'b1;
    end else begin
      r.level = bvp_pkg::PCT_W'(charge_at_mv(mv));
      r.ext   = 1'b0;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  // Randomize output backpressure
  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Compare each output transaction against the oldest expectation
  always @(posedge clk) begin
    charge_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_levels.size() == 0) begin
        report_mismatch($sformatf("unexpected level=%0d ext=%0b",
                                  m_axis_tdata[6:0], m_axis_tuser));
      end else begin
        want = expected_levels.pop_front();
        if (m_axis_tdata[6:0] !== want.level)
          report_mismatch($sformatf("battery_level %0d, want %0d",
                                    m_axis_tdata[6:0], want.level));
        if (m_axis_tuser !== want.ext)
          report_mismatch($sformatf("external_power %0b, want %0b",
                                    m_axis_tuser, want.ext));
      end
    end
  end

  // Offer one sample and hold it until the transaction completes
  task automatic send_sample(input logic [bvp_pkg::ADC_W-1:0] adc, input logic ok);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, adc};
    s_axis_tuser  <= ok;
    do @(posedge clk); while (!s_axis_tready);
    if (ok) expected_levels.push_back(predict_reading(adc));
  endtask

  // Drop valid, wait for all results, then let the pipeline empty
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_levels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Drive one register write; the caller drops the write enable
  task automatic write_reg(input logic [bvp_pkg::REG_IDX_W-1:0] idx, input int value);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= bvp_pkg::WIN_W'(value);
    @(posedge clk);
    case (idx)
      bvp_pkg::REG_VALID_MIN: window_min_mv = bvp_pkg::WIN_W'(value);
      bvp_pkg::REG_VALID_MAX: window_max_mv = bvp_pkg::WIN_W'(value);
      bvp_pkg::REG_RATIO:     divider       = bvp_pkg::RATIO_W'(value);
      default: ;
    endcase
  endtask

  task automatic set_config(input int min_mv, input int max_mv, input int ratio);
    wait_drained();
    write_reg(bvp_pkg::REG_VALID_MIN, min_mv);
    write_reg(bvp_pkg::REG_VALID_MAX, max_mv);
    write_reg(bvp_pkg::REG_RATIO, ratio);
    cfg_we <= 1'b0;
  endtask

  // Default registers: every curve point, window edges, failed reads
  task automatic test_reset_window();
    int i;
    for (i = 0; i < bvp_pkg::CURVE_POINTS; i++)
      send_sample(bvp_pkg::ADC_W'(LIPO_MV[i] / 2), 1'b1);
    send_sample(12'd1350, 1'b1);  // window floor, below curve
    send_sample(12'd1349, 1'b1);  // just under the window
    send_sample(12'd2175, 1'b1);  // window ceiling, above curve
    send_sample(12'd2176, 1'b1);  // just over the window
    send_sample(12'd1999, 1'b1);  // inside a segment
    send_sample(12'd0, 1'b0);
    send_sample(12'd4095, 1'b0);
    send_sample(12'd4095, 1'b1);
  endtask

  // Divider and window extremes
  task automatic test_config_extremes();
    set_config(0, 16383, 0);
    send_sample(12'd4095, 1'b1);  // zero divider gives 0 mV
    set_config(0, 16383, 7);
    send_sample(12'd4095, 1'b1);
    send_sample(12'd2340, 1'b1);
    set_config(0, 16383, 1);
    send_sample(12'd3001, 1'b1);
    send_sample(12'd4199, 1'b1);
    set_config(16383, 0, 4);      // inverted window
    send_sample(12'd1000, 1'b1);
    send_sample(12'd0, 1'b1);
    set_config(3700, 3700, 1);    // single-point window
    send_sample(12'd3700, 1'b1);
    send_sample(12'd3699, 1'b1);
  endtask

  task automatic pick_random_config();
    case ($urandom_range(5))
      0: set_config(0, 16383, $urandom_range(7));
      1: set_config($urandom_range(16383), $urandom_range(16383), $urandom_range(7));
      default: set_config($urandom_range(2500, 3200), $urandom_range(4000, 4500),
                          $urandom_range(1, 4));
    endcase
  endtask

  // Mostly realistic battery voltages, some raw noise
  task automatic send_random_sample();
    logic ok;
    int   mv;
    int   adc;
    ok = ($urandom_range(99) >= 10);
    if ($urandom_range(3) == 0 || divider == 0) begin
      adc = $urandom_range(4095);
    end else begin
      mv  = $urandom_range(2600, 4450);
      adc = mv / int'(divider);
      if (adc > 4095) adc = 4095;
    end
    send_sample(bvp_pkg::ADC_W'(adc), ok);
  endtask

  task automatic test_random_phase(input int s_pct, input int r_pct, input int n);
    int k;
    wait_drained();
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (k = 0; k < 3; k++) begin
      pick_random_config();
      repeat (n / 3) send_random_sample();
    end
  endtask

  initial begin
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_addr      = bvp_pkg::REG_VALID_MIN;
    cfg_data      = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    error_count   = 0;
    send_idle_pct = 9;
    recv_idle_pct = 73;
    window_min_mv = bvp_pkg::VALID_MIN_RST;
    window_max_mv = bvp_pkg::VALID_MAX_RST;
    divider       = bvp_pkg::RATIO_RST;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_window();
    test_config_extremes();
    test_random_phase(9, 73, 216);
    test_random_phase(73, 9, 216);
    test_random_phase(0, 0, 216);
    wait_drained();

    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
